// ----- design/ntc_pkg.sv -----
// Package: resistance table and shared types for the NTC temperature block.
`timescale 1ns / 1ps
`default_nettype none
package ntc_pkg;
   localparam int TABLE_LAST = 160;
   localparam logic [15:0] OHMS_TABLE [0:TABLE_LAST] = '{
      16'd29686,16'd27929,16'd26277,16'd24726,16'd23270,16'd21958,16'd20664,16'd19453,
      16'd18321,16'd17261,16'd16268,16'd15348,16'd14486,16'd13677,16'd12916,16'd12202,
      16'd11536,16'd10909,16'd10319,16'd9764,16'd9241,16'd8777,16'd8338,16'd7922,
      16'd7527,16'd7152,16'd6765,16'd6400,16'd6060,16'd5737,16'd5434,16'd5153,
      16'd4888,16'd4638,16'd4402,16'd4180,16'd3970,16'd3772,16'd3585,16'd3409,
      16'd3242,16'd3083,16'd2933,16'd2790,16'd2656,16'd2529,16'd2409,16'd2296,
      16'd2188,16'd2086,16'd1990,16'd1895,16'd1806,16'd1722,16'd1642,16'd1567,
      16'd1496,16'd1429,16'd1365,16'd1305,16'd1247,16'd1193,16'd1141,16'd1092,
      16'd1045,16'd1000,16'd958,16'd917,16'd879,16'd842,16'd807,16'd773,
      16'd742,16'd711,16'd682,16'd654,16'd628,16'd602,16'd578,16'd555,
      16'd533,16'd512,16'd491,16'd472,16'd453,16'd436,16'd419,16'd403,
      16'd388,16'd373,16'd359,16'd345,16'd333,16'd320,16'd308,16'd297,
      16'd296,16'd275,16'd265,16'd255,16'd246,16'd237,16'd229,16'd222,
      16'd214,16'd207,16'd200,16'd193,16'd187,16'd180,16'd174,16'd168,
      16'd163,16'd157,16'd152,16'd147,16'd142,16'd138,16'd133,16'd129,
      16'd125,16'd121,16'd117,16'd113,16'd110,16'd106,16'd103,16'd100,
      16'd97,16'd94,16'd91,16'd88,16'd85,16'd83,16'd80,16'd78,
      16'd76,16'd73,16'd71,16'd69,16'd67,16'd65,16'd63,16'd62,
      16'd60,16'd58,16'd57,16'd55,16'd53,16'd52,16'd50,16'd49,
      16'd48,16'd46,16'd45,16'd44,16'd43,16'd41,16'd40,16'd39,
      16'd37};
   localparam logic [9:0] RES_SCALE = 10'd1000;
   localparam logic [16:0] RES_MAX = 17'd65535;

   typedef struct packed {
      logic start_div;   // load divider with the latched code
      logic start_srch;  // start table search on quotient
      logic store;       // write index into ring
      logic advance;     // step write position / lap
      logic start_filt;  // begin filtering one slot
      logic next_slot;   // step filter slot
   } ctl_type;

   typedef struct packed {
      logic div_done;
      logic srch_done;
      logic filt_done;
      logic last_slot;
   } sts_type;
endpackage
`default_nettype wire

// ----- design/ntc_datapath.sv -----
// Datapath: divider, table search, sample ring and filter accumulator.
`timescale 1ns / 1ps
`default_nettype none
module ntc_datapath
   import ntc_pkg::*;
#(
   parameter int NUM_SLOTS  = 8,
   parameter int RING_DEPTH = 8
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load,
   input  wire logic [2:0] in_slot,
   input  wire logic [9:0] in_code,
   input  wire ctl_type    ctl,
   output sts_type         sts,
   output logic [2:0]      res_slot,
   output logic [7:0]      res_index,
   output logic            res_last
);
   localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CW = $clog2(RING_DEPTH + 1);
   localparam int AW = SW + PW;
   localparam int MW = 8 + CW;
   localparam int DEPTH = NUM_SLOTS * RING_DEPTH;

   logic [2:0]  slot_ff;
   logic [9:0]  code_ff;
   // restoring divider: 20-bit dividend, 11-bit divisor
   logic [19:0] quo_ff, quo_in;
   logic [10:0] rem_ff, rem_in;
   logic [4:0]  dcnt_ff, dcnt_in;
   logic        dbusy_ff, dbusy_in;
   logic [16:0] r_ff;
   logic [7:0]  n_ff, n_in;
   logic        sbusy_ff, sbusy_in;
   logic        sdone_ff, sdone_in;
   logic [PW-1:0] wpos_ff, wpos_in;
   logic        first_ff, first_in;
   logic [SW-1:0] fslot_ff, fslot_in;
   logic [CW-1:0] k_ff, k_in;
   logic        fbusy_ff, fbusy_in;
   logic        fdone_ff, fdone_in;
   logic        rd_pend_ff;
   logic [MW-1:0] sum_ff, sum_in;
   logic [7:0]  mx_ff, mx_in, mn_ff, mn_in;
   logic [7:0]  rd_ff;
   logic [7:0]  ring [0:DEPTH-1];
   // result division by small count (iterative subtract)
   logic [MW-1:0] dv_ff, dv_in;
   logic [7:0]  q_ff, q_in;
   logic        qbusy_ff, qbusy_in;
   logic [CW-1:0] cnt;
   logic [AW-1:0] waddr, raddr;
   logic [11:0] trial;
   logic [16:0] rsat;

   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff <= in_slot;
         code_ff <= in_code;
      end
   end

   assign trial = {rem_ff, quo_ff[19]} - {1'b0, 11'd1024 - {1'b0, code_ff}};
   assign rsat  = (quo_ff > {3'b0, RES_MAX}) ? RES_MAX : quo_ff[16:0];

   always_comb begin
      quo_in = quo_ff; rem_in = rem_ff; dcnt_in = dcnt_ff; dbusy_in = dbusy_ff;
      if (ctl.start_div) begin
         quo_in = 20'(code_ff) * 20'(RES_SCALE);
         rem_in = '0; dcnt_in = '0; dbusy_in = 1'b1;
      end else if (dbusy_ff) begin
         if (!trial[11]) begin
            rem_in = trial[10:0];
            quo_in = {quo_ff[18:0], 1'b1};
         end else begin
            rem_in = {rem_ff[9:0], quo_ff[19]};
            quo_in = {quo_ff[18:0], 1'b0};
         end
         dcnt_in = dcnt_ff + 5'd1;
         if (dcnt_ff == 5'd19) dbusy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in; rem_ff <= rem_in; dcnt_ff <= dcnt_in;
      if (reset) dbusy_ff <= 1'b0; else dbusy_ff <= dbusy_in;
   end
   assign sts.div_done = !dbusy_ff;

   // linear table search, one entry per cycle
   always_comb begin
      n_in = n_ff; sbusy_in = sbusy_ff; sdone_in = 1'b0;
      if (ctl.start_srch) begin
         n_in = '0; sbusy_in = 1'b1;
         if (rsat > {1'b0, OHMS_TABLE[0]}) begin
            sbusy_in = 1'b0; sdone_in = 1'b1;
         end else if (rsat < {1'b0, OHMS_TABLE[TABLE_LAST]}) begin
            n_in = 8'(TABLE_LAST); sbusy_in = 1'b0; sdone_in = 1'b1;
         end
      end else if (sbusy_ff) begin
         if (n_ff < 8'(TABLE_LAST) && r_ff < {1'b0, OHMS_TABLE[n_ff]}) begin
            n_in = n_ff + 8'd1;
         end else begin
            sbusy_in = 1'b0; sdone_in = 1'b1;
            if (n_ff != 8'd0 &&
                (r_ff - {1'b0, OHMS_TABLE[n_ff]}) > ({1'b0, OHMS_TABLE[n_ff - 8'd1]} - r_ff))
               n_in = n_ff - 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start_srch) r_ff <= rsat;
      n_ff <= n_in;
      if (reset) begin
         sbusy_ff <= 1'b0; sdone_ff <= 1'b0;
      end else begin
         sbusy_ff <= sbusy_in; sdone_ff <= sdone_in;
      end
   end
   assign sts.srch_done = sdone_ff;

   // write position and lap
   always_comb begin
      wpos_in = wpos_ff; first_in = first_ff;
      if (ctl.advance) begin
         if (wpos_ff == PW'(RING_DEPTH - 1)) begin
            wpos_in = '0; first_in = 1'b0;
         end else begin
            wpos_in = wpos_ff + PW'(1);
         end
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         wpos_ff <= '0; first_ff <= 1'b1;
      end else begin
         wpos_ff <= wpos_in; first_ff <= first_in;
      end
   end

   assign waddr = AW'(slot_ff[SW-1:0] * RING_DEPTH) + AW'(wpos_ff);
   assign raddr = AW'(fslot_ff * RING_DEPTH) + AW'(k_ff[PW-1:0]);
   assign cnt   = first_ff ? CW'(wpos_ff) : CW'(RING_DEPTH);

   always_ff @(posedge clock) begin
      if (ctl.store) ring[waddr] <= n_ff;
      rd_ff <= ring[raddr];
   end

   // filter: read entries one per cycle, then divide by count (after first lap: drop max, min)
   always_comb begin
      fslot_in = fslot_ff; k_in = k_ff; fbusy_in = fbusy_ff; fdone_in = 1'b0;
      sum_in = sum_ff; mx_in = mx_ff; mn_in = mn_ff;
      dv_in = dv_ff; q_in = q_ff; qbusy_in = qbusy_ff;
      if (ctl.advance) fslot_in = '0;
      if (ctl.next_slot) fslot_in = fslot_ff + SW'(1);
      if (ctl.start_filt) begin
         k_in = '0; fbusy_in = 1'b1; sum_in = '0; mx_in = 8'd0; mn_in = 8'hFF;
         if (cnt == '0) begin
            fbusy_in = 1'b0; dv_in = '0; q_in = '0; qbusy_in = 1'b0; fdone_in = 1'b1;
         end
      end else if (fbusy_ff) begin
         if (rd_pend_ff) begin
            sum_in = sum_ff + MW'(rd_ff);
            if (rd_ff > mx_ff) mx_in = rd_ff;
            if (rd_ff < mn_ff) mn_in = rd_ff;
         end
         if (k_ff < cnt) begin
            k_in = k_ff + CW'(1);
         end else if (!rd_pend_ff) begin
            fbusy_in = 1'b0; qbusy_in = 1'b1; q_in = '0;
            dv_in = first_ff ? sum_ff : sum_ff - MW'(mx_ff) - MW'(mn_ff);
         end
      end else if (qbusy_ff) begin
         if (first_ff ? (dv_ff >= MW'(cnt)) : (dv_ff >= MW'(RING_DEPTH - 2))) begin
            dv_in = dv_ff - (first_ff ? MW'(cnt) : MW'(RING_DEPTH - 2));
            q_in = q_ff + 8'd1;
         end else begin
            qbusy_in = 1'b0; fdone_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in; mx_ff <= mx_in; mn_ff <= mn_in; k_ff <= k_in;
      dv_ff <= dv_in; q_ff <= q_in;
      if (reset) begin
         fslot_ff <= '0; fbusy_ff <= 1'b0; fdone_ff <= 1'b0; qbusy_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
      end else begin
         fslot_ff <= fslot_in; fbusy_ff <= fbusy_in; fdone_ff <= fdone_in;
         qbusy_ff <= qbusy_in;
         rd_pend_ff <= fbusy_ff && !ctl.start_filt && (k_ff < cnt);
      end
   end

   assign sts.filt_done = fdone_ff;
   assign sts.last_slot = (fslot_ff == SW'(NUM_SLOTS - 1));
   assign res_slot  = 3'(fslot_ff);
   assign res_index = q_ff;
   assign res_last  = sts.last_slot;
endmodule
`default_nettype wire

// ----- design/ntc_ctrl.sv -----
// Controller: sequences conversion, storage and per-slot filtering.
`timescale 1ns / 1ps
`default_nettype none
module ntc_ctrl
   import ntc_pkg::*;
#(
   parameter int NUM_SLOTS = 8
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   input  wire logic [2:0] in_slot,
   output logic            in_ready,
   output logic            load,
   output logic            out_valid,
   input  wire logic       out_ready,
   output ctl_type         ctl,
   input  wire sts_type    sts
);
   localparam logic [2:0] S_IDLE = 3'd0, S_DIV = 3'd1, S_WAIT = 3'd2, S_SRCH = 3'd3,
                          S_FILT = 3'd4, S_OUT = 3'd5;
   logic [2:0] state_ff, state_in;
   logic       last_ff, last_in;
   logic       started_ff, started_in;

   assign in_ready  = (state_ff == S_IDLE);
   assign load      = in_valid && in_ready;
   assign out_valid = (state_ff == S_OUT);

   always_comb begin
      state_in = state_ff; last_in = last_ff; started_in = 1'b0;
      ctl = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (load && (32'(in_slot) < NUM_SLOTS)) begin
               last_in = (in_slot == 3'(NUM_SLOTS - 1));
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            ctl.start_div = 1'b1; state_in = S_WAIT; started_in = 1'b1;
         end
         S_WAIT: begin
            if (!started_ff && sts.div_done) begin
               ctl.start_srch = 1'b1; state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            if (sts.srch_done) begin
               ctl.store = 1'b1;
               if (last_ff) begin
                  ctl.advance = 1'b1; state_in = S_FILT; started_in = 1'b1;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_FILT: begin
            if (started_ff) ctl.start_filt = 1'b1;
            else if (sts.filt_done) state_in = S_OUT;
         end
         S_OUT: begin
            if (out_ready) begin
               if (sts.last_slot) begin
                  state_in = S_IDLE;
               end else begin
                  ctl.next_slot = 1'b1; state_in = S_FILT; started_in = 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; last_ff <= 1'b0; started_ff <= 1'b0;
      end else begin
         state_ff <= state_in; last_ff <= last_in; started_ff <= started_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (ctl.store && !last_ff) |=> in_ready) else $error("ring write did not release input");
   assert property (@(posedge clock) disable iff (reset)
      !(in_ready && out_valid)) else $error("input and output open together");
   assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> out_valid) else $error("result dropped under stall");
endmodule
`default_nettype wire

// ----- design/ntc_temperature_trimmed_mean.sv -----
// Top level: NTC thermistor temperature with per-slot trimmed-mean filter.
// req_ channel: one converter code per sensor slot, slots 0..NUM_SLOTS-1 in order.
// rsp_ channel: after the last slot, NUM_SLOTS filtered indices, slot 0 first,
//   tlast marking the last slot; temperature in C is index minus 40.
// One item at a time: each code passes a 20-step bit-serial divider, then a
// linear search of the 161-entry resistance table (one entry a cycle), before
// req_tready returns.
// Each result reads the slot's ring row one entry a cycle and divides the sum
// (less max and min once the ring has wrapped) by repeated subtraction.
// Reset clears the write position and lap flag; ring contents are undefined
// until written. While the receiver stalls the result holds and no input is taken.
`timescale 1ns / 1ps
`default_nettype none
module ntc_temperature_trimmed_mean
   import ntc_pkg::*;
#(
   parameter int NUM_SLOTS  = 8,
   parameter int RING_DEPTH = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // slot[2:0], adc_code[12:3]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // out_slot[2:0], temperature_index[10:3]
   output logic             rsp_tlast
);
   ctl_type    ctl;
   sts_type    sts;
   logic       load;
   logic [2:0] res_slot;
   logic [7:0] res_index;
   logic       res_last;

   ntc_ctrl #(.NUM_SLOTS(NUM_SLOTS)) u_ctrl (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_slot(req_tdata[2:0]),
      .in_ready(req_tready), .load(load), .out_valid(rsp_tvalid),
      .out_ready(rsp_tready), .ctl(ctl), .sts(sts));

   ntc_datapath #(.NUM_SLOTS(NUM_SLOTS), .RING_DEPTH(RING_DEPTH)) u_dp (
      .clock(clock), .reset(reset), .load(load), .in_slot(req_tdata[2:0]),
      .in_code(req_tdata[12:3]), .ctl(ctl), .sts(sts), .res_slot(res_slot),
      .res_index(res_index), .res_last(res_last));

   assign rsp_tdata = {5'd0, res_index, res_slot};
   assign rsp_tlast = res_last;
endmodule
`default_nettype wire

// ----- tb/sv/ntc_temperature_trimmed_mean_test.sv -----
// Testbench: checks the NTC trimmed-mean temperature block against its own predictor.
`timescale 1ns / 1ps
`default_nettype none
module ntc_temperature_trimmed_mean_test;
   import ntc_pkg::*;

   localparam int NUM_SLOTS  = 8;
   localparam int RING_DEPTH = 8;
   localparam logic [2:0] LAST_SLOT = 3'(NUM_SLOTS - 1);

   typedef struct packed {
      logic [2:0] out_slot;
      logic [7:0] temperature_index;
      logic       last_of_round;
   } temp_result_type;

   logic clock, reset;
   logic req_tvalid, req_tready;
   logic [15:0] req_tdata;
   logic rsp_tvalid, rsp_tready;
   logic [15:0] rsp_tdata;
   logic rsp_tlast;

   ntc_temperature_trimmed_mean #(.NUM_SLOTS(NUM_SLOTS), .RING_DEPTH(RING_DEPTH)) DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast));

   // predictor state
   logic [7:0] ring [NUM_SLOTS][RING_DEPTH];
   int unsigned wr_pos;
   bit filling;
   temp_result_type expected_temps[$];
   int errors, items_sent, results_seen;
   bit long_hold;

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("timeout");
      $display("** ntc_temperature_trimmed_mean: FAILED **");
      $finish;
   end

   function automatic logic [7:0] code_to_index(logic [9:0] code);
      int unsigned r, n;
      r = (1000 * code) / (1024 - code);
      if (r > 65535) r = 65535;
      if (r > OHMS_TABLE[0]) return 8'd0;
      if (r < OHMS_TABLE[TABLE_LAST]) return 8'(TABLE_LAST);
      n = 0;
      while (n < TABLE_LAST && r < OHMS_TABLE[n]) n++;
      if (n > 0 && (r - OHMS_TABLE[n]) > (OHMS_TABLE[n-1] - r)) n--;
      return 8'(n);
   endfunction

   function automatic logic [7:0] filtered_index(int s);
      int unsigned sum, mx, mn;
      sum = 0;
      if (filling) begin
         if (wr_pos == 0) return 8'd0;
         for (int k = 0; k < wr_pos; k++) sum += ring[s][k];
         return 8'(sum / wr_pos);
      end
      mx = ring[s][0];
      mn = ring[s][0];
      for (int k = 0; k < RING_DEPTH; k++) begin
         if (ring[s][k] > mx) mx = ring[s][k];
         if (ring[s][k] < mn) mn = ring[s][k];
         sum += ring[s][k];
      end
      return 8'((sum - mx - mn) / (RING_DEPTH - 2));
   endfunction

   task automatic predict_item(logic [2:0] slot, logic [9:0] code);
      temp_result_type t;
      if (slot >= NUM_SLOTS) return;
      if (wr_pos >= RING_DEPTH) wr_pos = 0;
      ring[slot][wr_pos] = code_to_index(code);
      if (slot != LAST_SLOT) return;
      wr_pos++;
      if (wr_pos >= RING_DEPTH) begin
         wr_pos = 0;
         filling = 0;
      end
      for (int s = 0; s < NUM_SLOTS; s++) begin
         t.out_slot = 3'(s);
         t.temperature_index = filtered_index(s);
         t.last_of_round = (s == NUM_SLOTS - 1);
         expected_temps.push_back(t);
      end
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // receiver: own stall pattern, plus one long hold-off
   int hold_count;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
         hold_count <= 0;
      end else if (long_hold && hold_count < 3000) begin
         hold_count <= hold_count + 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= ($urandom_range(0, 9) < 3) ? 1'b0 : 1'b1;
      end
   end

   always @(posedge clock) begin
      temp_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.out_slot = rsp_tdata[2:0];
         got.temperature_index = rsp_tdata[10:3];
         got.last_of_round = rsp_tlast;
         results_seen++;
         if (expected_temps.size() == 0) begin
            report_mismatch("unexpected item", got.out_slot, -1);
         end else begin
            want = expected_temps.pop_front();
            if (got.out_slot != want.out_slot)
               report_mismatch("out_slot", got.out_slot, want.out_slot);
            if (got.temperature_index != want.temperature_index)
               report_mismatch("temperature_index", got.temperature_index,
                  want.temperature_index);
            if (got.last_of_round != want.last_of_round)
               report_mismatch("last_of_round", got.last_of_round, want.last_of_round);
         end
      end
   end

   // optional typed expectation for directed rows
   task automatic send_item(logic [2:0] slot, logic [9:0] code, int idx_want = -1);
      int gap;
      if ($urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 12);
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {3'b000, code, slot};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_item(slot, code);
      items_sent++;
      if (idx_want >= 0 && code_to_index(code) != idx_want)
         report_mismatch("directed lookup", code_to_index(code), idx_want);
   endtask

   task automatic send_round(int hot);
      for (int s = 0; s < NUM_SLOTS; s++)
         send_item(3'(s), hot ? 10'($urandom_range(0, 1023)) : 10'($urandom_range(200, 900)));
   endtask

   // directed rows: slot, code, expected lookup index (-1 = predictor only)
   typedef struct { logic [2:0] slot; logic [9:0] code; int idx; } row_type;
   row_type directed[] = '{
      '{3'd0, 10'd0,    160}, '{3'd1, 10'd1023, 0}, '{3'd2, 10'd1000, 0},
      '{3'd3, 10'd990,  0},   '{3'd4, 10'd38,   160}, '{3'd5, 10'd512, -1},
      '{3'd6, 10'd341,  -1},  '{3'd7, 10'd682,  -1},
      '{3'd0, 10'd995,  -1},  '{3'd1, 10'd1,    160}, '{3'd2, 10'd700, -1},
      '{3'd3, 10'd300,  -1},  '{3'd4, 10'd100,  -1}, '{3'd5, 10'd900, -1},
      '{3'd6, 10'd555,  -1},  '{3'd7, 10'd170,  -1}
   };

   initial begin
      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      long_hold = 0;
      errors = 0;
      items_sent = 0;
      results_seen = 0;
      wr_pos = 0;
      filling = 1;
      foreach (ring[s, k]) ring[s][k] = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (directed[i]) send_item(directed[i].slot, directed[i].code, directed[i].idx);
      // ignored slots never exist with eight slots; out-of-order writes within a round
      send_item(3'd3, 10'd450);
      send_item(3'd3, 10'd460);
      for (int s = 0; s < NUM_SLOTS; s++) send_item(3'(s), 10'd1023 - 10'(s));
      long_hold = 1;
      send_round(1);
      send_round(0);
      // stray single items only once every ring column holds data
      while (items_sent < 130) begin
         if (!filling && $urandom_range(0, 9) == 0)
            send_item(3'($urandom_range(0, 7)), 10'($urandom_range(0, 1023)));
         else
            send_round($urandom_range(0, 1));
      end
      req_tvalid <= 0;
      while (expected_temps.size() != 0) @(posedge clock);
      repeat (3000) @(posedge clock);
      $display("%0d items sent, %0d filtered results checked, across first lap and wrap",
         items_sent, results_seen);
      if (errors == 0 && expected_temps.size() == 0) begin
         $display("** ntc_temperature_trimmed_mean: PASSED **");
      end else begin
         $display("** ntc_temperature_trimmed_mean: FAILED **");
      end
      $finish;
   end
endmodule
`default_nettype wire
